>>> src/hsv_to_rgb_pixel_macros.svh
// assertion macros for the hsv to rgb pixel converter
// included by the top level; depends on nothing else
`ifndef HSV_TO_RGB_PIXEL_MACROS_SVH
`define HSV_TO_RGB_PIXEL_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define HSVRGB_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hsv_to_rgb_pixel: check failed");

// next-cycle implication, disabled during reset
`define HSVRGB_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hsv_to_rgb_pixel: check failed");

`else

`define HSVRGB_ASSERT_IMP(label, clk, rst_n, pre, post)
`define HSVRGB_ASSERT_NXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> src/hsvrgb_pkg.sv
// shared widths, constants and sector codes for the hsv to rgb converter
// no dependencies
package hsvrgb_pkg;

  // fixed field widths
  localparam int HUE_W     = 15;
  localparam int UNIT_W    = 9;
  localparam int UNIT_FRAC = 8;
  localparam int UNIT_ONE  = 256;
  localparam int CH_W      = 8;
  // 255 * v fits in 16 bits for v up to 1.0
  localparam int VS_W      = 16;

  // hue geometry
  localparam int DEG_PER_SECTOR = 60;
  localparam int SECTORS        = 6;

  // parameter defaults
  localparam int HUE_FRAC_BITS_DEF    = 6;
  localparam int SECTOR_FRAC_BITS_DEF = 12;

  // sector codes
  localparam int SECT_W = 3;
  typedef logic [SECT_W-1:0] sector_t;
  localparam sector_t SECT_RED_YEL = 3'd0;
  localparam sector_t SECT_YEL_GRN = 3'd1;
  localparam sector_t SECT_GRN_CYN = 3'd2;
  localparam sector_t SECT_CYN_BLU = 3'd3;
  localparam sector_t SECT_BLU_MAG = 3'd4;
  localparam sector_t SECT_MAG_RED = 3'd5;

  // bits of the remainder within one sector
  function automatic int rem_w(int hue_frac);
    return $clog2(DEG_PER_SECTOR << hue_frac);
  endfunction

endpackage

>>> src/hsvrgb_split.sv
// front pipeline stages: clamp inputs, form 255 * v, split hue into sector and remainder
// depends on hsvrgb_pkg
module hsvrgb_split #(
  parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic [hsvrgb_pkg::HUE_W-1:0]                  hue_i,
  input  logic [hsvrgb_pkg::UNIT_W-1:0]                 sat_i,
  input  logic [hsvrgb_pkg::UNIT_W-1:0]                 val_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output logic [hsvrgb_pkg::rem_w(HUE_FRAC_BITS)-1:0]   rem_o,
  output hsvrgb_pkg::sector_t                           sector_o,
  output logic [hsvrgb_pkg::UNIT_W-1:0]                 sat_o,
  output logic [hsvrgb_pkg::VS_W-1:0]                   vs_o
);
  import hsvrgb_pkg::*;

  localparam logic [63:0] SPAN    = 64'(DEG_PER_SECTOR) << HUE_FRAC_BITS;
  localparam logic [63:0] FULL    = SPAN * 64'(SECTORS);
  localparam logic [63:0] HUE_MAX = (64'd1 << HUE_W) - 64'd1;
  localparam int SPAN_W = $clog2(SPAN + 64'd1);
  localparam int FULL_W = $clog2(FULL + 64'd1);
  localparam int REM_W  = rem_w(HUE_FRAC_BITS);
  localparam int QS_RAW = $clog2(HUE_MAX / SPAN + 64'd1);
  localparam int QT_RAW = $clog2(HUE_MAX / FULL + 64'd1);
  localparam int QS_W   = (QS_RAW > 0) ? QS_RAW : 1;
  localparam int QT_W   = (QT_RAW > 0) ? QT_RAW : 1;
  // reciprocal multipliers, exact for every 15-bit hue
  localparam int QS_K   = HUE_W + SPAN_W;
  localparam int QT_K   = HUE_W + FULL_W;
  localparam int QS_PW  = QS_K + QS_W;
  localparam int QT_PW  = QT_K + QT_W;
  localparam logic [63:0] QS_M = ((64'd1 << QS_K) + SPAN - 64'd1) / SPAN;
  localparam logic [63:0] QT_M = ((64'd1 << QT_K) + FULL - 64'd1) / FULL;
  // width for the remainder and sector subtractions
  localparam int SW = ((SPAN_W > HUE_W) ? SPAN_W : HUE_W) + 1;

  // stage valid bits and advance enables
  logic [2:0] vld_q;
  logic [2:0] adv;

  assign adv[2]  = !vld_q[2] || ready_i;
  assign adv[1]  = !vld_q[1] || adv[2];
  assign adv[0]  = !vld_q[0] || adv[1];
  assign ready_o = adv[0];
  assign valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 1: clamp saturation and value to 1.0
  logic [HUE_W-1:0]  hue1_q;
  logic [UNIT_W-1:0] sat1_q, val1_q, sat1_d, val1_d;

  assign sat1_d = (sat_i > UNIT_W'(UNIT_ONE)) ? UNIT_W'(UNIT_ONE) : sat_i;
  assign val1_d = (val_i > UNIT_W'(UNIT_ONE)) ? UNIT_W'(UNIT_ONE) : val_i;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      hue1_q <= hue_i;
      sat1_q <= sat1_d;
      val1_q <= val1_d;
    end
  end

  // stage 2: hue divided by the sector span and by a full turn
  logic [QS_PW-1:0]  qs_prod;
  logic [QT_PW-1:0]  qt_prod;
  logic [QS_W-1:0]   qs2_q;
  logic [QT_W-1:0]   qt2_q;
  logic [HUE_W-1:0]  hue2_q;
  logic [UNIT_W-1:0] sat2_q;
  logic [VS_W-1:0]   vs2_q, vs2_d;

  assign qs_prod = QS_PW'(hue1_q) * QS_PW'(QS_M);
  assign qt_prod = QT_PW'(hue1_q) * QT_PW'(QT_M);
  // 255 * v as (v << 8) - v
  assign vs2_d   = VS_W'({val1_q, {UNIT_FRAC{1'b0}}} - {{UNIT_FRAC{1'b0}}, val1_q});

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      qs2_q  <= qs_prod[QS_PW-1:QS_K];
      qt2_q  <= qt_prod[QT_PW-1:QT_K];
      hue2_q <= hue1_q;
      sat2_q <= sat1_q;
      vs2_q  <= vs2_d;
    end
  end

  // stage 3: remainder within the sector and sector modulo six
  logic [SW-1:0] qs_span, rem_wide, sec_wide;

  assign qs_span  = SW'(qs2_q) * SW'(SPAN);
  assign rem_wide = SW'(hue2_q) - qs_span;
  assign sec_wide = SW'(qs2_q) - SW'(qt2_q) * SW'(SECTORS);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      rem_o    <= rem_wide[REM_W-1:0];
      sector_o <= sec_wide[SECT_W-1:0];
      sat_o    <= sat2_q;
      vs_o     <= vs2_q;
    end
  end

endmodule

>>> src/hsvrgb_blend.sv
// middle pipeline stages: sector fraction, then the p, q, t and v bytes
// depends on hsvrgb_pkg
module hsvrgb_blend #(
  parameter int HUE_FRAC_BITS    = hsvrgb_pkg::HUE_FRAC_BITS_DEF,
  parameter int SECTOR_FRAC_BITS = hsvrgb_pkg::SECTOR_FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic [hsvrgb_pkg::rem_w(HUE_FRAC_BITS)-1:0]   rem_i,
  input  hsvrgb_pkg::sector_t                           sector_i,
  input  logic [hsvrgb_pkg::UNIT_W-1:0]                 sat_i,
  input  logic [hsvrgb_pkg::VS_W-1:0]                   vs_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output hsvrgb_pkg::sector_t                           sector_o,
  output logic [hsvrgb_pkg::CH_W-1:0]                   p_o,
  output logic [hsvrgb_pkg::CH_W-1:0]                   q_o,
  output logic [hsvrgb_pkg::CH_W-1:0]                   t_o,
  output logic [hsvrgb_pkg::CH_W-1:0]                   vv_o
);
  import hsvrgb_pkg::*;

  localparam int S = SECTOR_FRAC_BITS;
  localparam logic [63:0] SPAN = 64'(DEG_PER_SECTOR) << HUE_FRAC_BITS;
  localparam int SPAN_W = $clog2(SPAN + 64'd1);
  localparam int REM_W  = rem_w(HUE_FRAC_BITS);
  // fraction f = (rem << S) / span through an exact reciprocal
  localparam int NUM_W  = REM_W + S;
  localparam int F_K    = NUM_W + SPAN_W;
  localparam int F_PW   = F_K + S;
  localparam logic [63:0] F_M = ((64'd1 << F_K) + SPAN - 64'd1) / SPAN;
  // p = 255v(1 - s) in Q9.16
  localparam int PP_W   = VS_W + UNIT_W;
  // q and t factors in Q1.(8 + S)
  localparam int QA_W   = S + UNIT_W;
  localparam int QP_W   = VS_W + QA_W;
  localparam logic [QA_W-1:0] FULL_V = QA_W'(UNIT_ONE) << S;
  localparam logic [S:0]      ONE_V  = (S + 1)'(1) << S;

  // stage valid bits and advance enables
  logic [2:0] vld_q;
  logic [2:0] adv;

  assign adv[2]  = !vld_q[2] || ready_i;
  assign adv[1]  = !vld_q[1] || adv[2];
  assign adv[0]  = !vld_q[0] || adv[1];
  assign ready_o = adv[0];
  assign valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 4: fraction within the sector and the p byte
  logic [F_PW-1:0]   f_prod;
  logic [PP_W-1:0]   p_prod;
  logic [UNIT_W-1:0] one_minus_s;
  logic [S-1:0]      f4_q;
  logic [UNIT_W-1:0] sat4_q;
  logic [VS_W-1:0]   vs4_q;
  logic [CH_W-1:0]   p4_q;
  sector_t           sec4_q;

  assign f_prod      = F_PW'({rem_i, {S{1'b0}}}) * F_PW'(F_M);
  assign one_minus_s = UNIT_W'(UNIT_ONE) - sat_i;
  assign p_prod      = PP_W'(vs_i) * PP_W'(one_minus_s);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      f4_q   <= f_prod[F_PW-1:F_K];
      sat4_q <= sat_i;
      vs4_q  <= vs_i;
      p4_q   <= p_prod[2*UNIT_FRAC +: CH_W];
      sec4_q <= sector_i;
    end
  end

  // stage 5: 1 - f*s and 1 - (1 - f)*s
  logic [S:0]      one_minus_f;
  logic [QA_W-1:0] fs, ofs;
  logic [QA_W-1:0] qa5_q, ta5_q;
  logic [VS_W-1:0] vs5_q;
  logic [CH_W-1:0] p5_q;
  sector_t         sec5_q;

  assign one_minus_f = ONE_V - (S + 1)'(f4_q);
  assign fs          = QA_W'(f4_q) * QA_W'(sat4_q);
  assign ofs         = QA_W'(one_minus_f) * QA_W'(sat4_q);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      qa5_q  <= FULL_V - fs;
      ta5_q  <= FULL_V - ofs;
      vs5_q  <= vs4_q;
      p5_q   <= p4_q;
      sec5_q <= sec4_q;
    end
  end

  // stage 6: scale by 255v and truncate to bytes
  logic [QP_W-1:0] q_prod, t_prod;

  assign q_prod = QP_W'(vs5_q) * QP_W'(qa5_q);
  assign t_prod = QP_W'(vs5_q) * QP_W'(ta5_q);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      q_o      <= q_prod[2*UNIT_FRAC+S +: CH_W];
      t_o      <= t_prod[2*UNIT_FRAC+S +: CH_W];
      vv_o     <= vs5_q[UNIT_FRAC +: CH_W];
      p_o      <= p5_q;
      sector_o <= sec5_q;
    end
  end

endmodule

>>> src/hsvrgb_route.sv
// output stage: routes p, q, t and v to red, green and blue by sector
// depends on hsvrgb_pkg
module hsvrgb_route (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  hsvrgb_pkg::sector_t         sector_i,
  input  logic [hsvrgb_pkg::CH_W-1:0] p_i,
  input  logic [hsvrgb_pkg::CH_W-1:0] q_i,
  input  logic [hsvrgb_pkg::CH_W-1:0] t_i,
  input  logic [hsvrgb_pkg::CH_W-1:0] vv_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [hsvrgb_pkg::CH_W-1:0] red_o,
  output logic [hsvrgb_pkg::CH_W-1:0] green_o,
  output logic [hsvrgb_pkg::CH_W-1:0] blue_o
);
  import hsvrgb_pkg::*;

  logic            vld_q;
  logic            adv;
  logic [CH_W-1:0] red_d, green_d, blue_d;

  assign adv     = !vld_q || ready_i;
  assign ready_o = adv;
  assign valid_o = vld_q;

  // hexcone routing
  always_comb begin
    unique case (sector_i)
      SECT_RED_YEL: begin red_d = vv_i; green_d = t_i;  blue_d = p_i;  end
      SECT_YEL_GRN: begin red_d = q_i;  green_d = vv_i; blue_d = p_i;  end
      SECT_GRN_CYN: begin red_d = p_i;  green_d = vv_i; blue_d = t_i;  end
      SECT_CYN_BLU: begin red_d = p_i;  green_d = q_i;  blue_d = vv_i; end
      SECT_BLU_MAG: begin red_d = t_i;  green_d = p_i;  blue_d = vv_i; end
      SECT_MAG_RED: begin red_d = vv_i; green_d = p_i;  blue_d = q_i;  end
      default:      begin red_d = vv_i; green_d = p_i;  blue_d = q_i;  end
    endcase
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= valid_i;
    end
  end

  // output bytes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_o   <= red_d;
      green_o <= green_d;
      blue_o  <= blue_d;
    end
  end

endmodule

>>> src/hsv_to_rgb_pixel.sv
// hsv to rgb pixel converter, top level
// depends on hsvrgb_pkg, hsvrgb_split, hsvrgb_blend, hsvrgb_route and the macro header
//
// Usage:
// - input channel (in_valid_i / in_ready_o) carries one pixel word: hue in
//   degrees times 2^HUE_FRAC_BITS, saturation and value as Q1.8 (256 = 1.0).
//   Hue at or past a full turn wraps; saturation or value above 1.0 clamps.
// - output channel (out_valid_o / out_ready_i) carries the red, green and
//   blue bytes of the same pixel, in input order.
// - pipeline: seven register stages, three in split, three in blend and one
//   output register in route.
// - throughput: one word per cycle while out_ready_i is high; every stage
//   is fully pipelined; widest path: one reciprocal multiply for the fraction.
// - stalls: when out_ready_i is low, words pile up in empty stages behind
//   the output register; in_ready_o falls only once all seven stages hold
//   a word. Nothing is dropped or repeated.
// - reset: rst_ni clears all stage valid bits asynchronously; the pipeline
//   is empty and ready right after reset.
`include "hsv_to_rgb_pixel_macros.svh"

module hsv_to_rgb_pixel #(
  parameter int HUE_FRAC_BITS    = hsvrgb_pkg::HUE_FRAC_BITS_DEF,
  parameter int SECTOR_FRAC_BITS = hsvrgb_pkg::SECTOR_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hsvrgb_pkg::HUE_W-1:0]  hue_i,
  input  logic [hsvrgb_pkg::UNIT_W-1:0] saturation_i,
  input  logic [hsvrgb_pkg::UNIT_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hsvrgb_pkg::CH_W-1:0]   red_o,
  output logic [hsvrgb_pkg::CH_W-1:0]   green_o,
  output logic [hsvrgb_pkg::CH_W-1:0]   blue_o
);
  import hsvrgb_pkg::*;

  localparam int REM_W = rem_w(HUE_FRAC_BITS);

  // split to blend
  logic              split_valid, blend_ready;
  logic [REM_W-1:0]  split_rem;
  sector_t           split_sector;
  logic [UNIT_W-1:0] split_sat;
  logic [VS_W-1:0]   split_vs;

  // blend to route
  logic            blend_valid, route_ready;
  sector_t         blend_sector;
  logic [CH_W-1:0] blend_p, blend_q, blend_t, blend_vv;

  // hue split and input clamp
  hsvrgb_split #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .hue_i   (hue_i),
    .sat_i   (saturation_i),
    .val_i   (value_i),
    .valid_o (split_valid),
    .ready_i (blend_ready),
    .rem_o   (split_rem),
    .sector_o(split_sector),
    .sat_o   (split_sat),
    .vs_o    (split_vs)
  );

  // fraction and channel bytes
  hsvrgb_blend #(
    .HUE_FRAC_BITS   (HUE_FRAC_BITS),
    .SECTOR_FRAC_BITS(SECTOR_FRAC_BITS)
  ) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (blend_ready),
    .rem_i   (split_rem),
    .sector_i(split_sector),
    .sat_i   (split_sat),
    .vs_i    (split_vs),
    .valid_o (blend_valid),
    .ready_i (route_ready),
    .sector_o(blend_sector),
    .p_o     (blend_p),
    .q_o     (blend_q),
    .t_o     (blend_t),
    .vv_o    (blend_vv)
  );

  // sector routing and output register
  hsvrgb_route u_route (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (blend_valid),
    .ready_o (route_ready),
    .sector_i(blend_sector),
    .p_i     (blend_p),
    .q_i     (blend_q),
    .t_i     (blend_t),
    .vv_i    (blend_vv),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  // input back-pressure only when the whole pipe is full and the output is stalled
  `HSVRGB_ASSERT_IMP(a_full_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // a stalled word between split and blend keeps its remainder and sector
  `HSVRGB_ASSERT_NXT(a_split_hold, clk_i, rst_ni, split_valid && !blend_ready, split_valid && $stable(split_rem) && $stable(split_sector))

  // a stalled word between blend and route keeps its p, q and t bytes
  `HSVRGB_ASSERT_NXT(a_blend_hold, clk_i, rst_ni, blend_valid && !route_ready, blend_valid && $stable(blend_p) && $stable(blend_q) && $stable(blend_t))

endmodule

>>> test/hsv_to_rgb_pixel_test.sv
// testbench for the hsv to rgb pixel converter: random handshake timing on both sides,
// every converted word checked against a local fixed-point hexcone predictor
// depends on hsvrgb_pkg and the hsv_to_rgb_pixel rtl
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_test;
  import hsvrgb_pkg::*;

  localparam int HFB = HUE_FRAC_BITS_DEF;
  localparam int SFB = SECTOR_FRAC_BITS_DEF;
  localparam longint unsigned SPAN = longint'(DEG_PER_SECTOR) << HFB;
  localparam longint unsigned TURN = SPAN * SECTORS;
  localparam int RANDOM_WORDS = 1650;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [UNIT_W-1:0] sat;
    logic [UNIT_W-1:0] val;
  } hsv_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [HUE_W-1:0]  hue_i = '0;
  logic [UNIT_W-1:0] saturation_i = '0;
  logic [UNIT_W-1:0] value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CH_W-1:0]   red_o;
  logic [CH_W-1:0]   green_o;
  logic [CH_W-1:0]   blue_o;

  hsv_word_t   hsv_todo_q[$];
  rgb_word_t   rgb_pending_q[$];
  int unsigned words_total = 0;
  int unsigned words_taken = 0;
  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        in_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;

  hsv_to_rgb_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // hexcone conversion: wrap hue, clamp s and v, blend and route by sector
  function automatic rgb_word_t hsv_to_rgb(hsv_word_t w);
    logic [63:0] h, s, v, rem, f, p, q, t, vv, full, one;
    sector_t     sect;
    rgb_word_t   rgb;
    h    = 64'(w.hue) % TURN;
    sect = sector_t'(h / SPAN);
    rem  = h % SPAN;
    f    = (rem << SFB) / SPAN;
    s    = (w.sat > UNIT_ONE) ? 64'(UNIT_ONE) : 64'(w.sat);
    v    = (w.val > UNIT_ONE) ? 64'(UNIT_ONE) : 64'(w.val);
    one  = 64'd1 << SFB;
    full = 64'(UNIT_ONE) << SFB;
    p    = (64'd255 * v * (64'(UNIT_ONE) - s)) >> (2 * UNIT_FRAC);
    q    = (64'd255 * v * (full - f * s)) >> (2 * UNIT_FRAC + SFB);
    t    = (64'd255 * v * (full - (one - f) * s)) >> (2 * UNIT_FRAC + SFB);
    vv   = (64'd255 * v) >> UNIT_FRAC;
    case (sect)
      SECT_RED_YEL: rgb = {vv[7:0], t[7:0], p[7:0]};
      SECT_YEL_GRN: rgb = {q[7:0], vv[7:0], p[7:0]};
      SECT_GRN_CYN: rgb = {p[7:0], vv[7:0], t[7:0]};
      SECT_CYN_BLU: rgb = {p[7:0], q[7:0], vv[7:0]};
      SECT_BLU_MAG: rgb = {t[7:0], p[7:0], vv[7:0]};
      default:      rgb = {vv[7:0], p[7:0], q[7:0]};
    endcase
    return rgb;
  endfunction

  // idle length: mostly none or short, now and then long enough to fill the pipeline
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // q1.8 unit: mostly in range, with the ends and some above 1.0
  function automatic logic [UNIT_W-1:0] pick_unit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return UNIT_W'($urandom_range(0, UNIT_ONE));
    if (r < 88) return ($urandom_range(0, 1) != 0) ? UNIT_W'(UNIT_ONE) : '0;
    return UNIT_W'($urandom_range(UNIT_ONE + 1, (1 << UNIT_W) - 1));
  endfunction

  // hue: mostly below a full turn, some near sector edges, some past the wrap
  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 75) return HUE_W'($urandom_range(0, int'(TURN) - 1));
    if (r < 90) begin
      k = $urandom_range(1, SECTORS) * int'(SPAN);
      return HUE_W'(k - 1 + $urandom_range(0, 2));
    end
    return HUE_W'($urandom_range(int'(TURN), (1 << HUE_W) - 1));
  endfunction

  task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned val);
    hsv_word_t w;
    w.hue = HUE_W'(hue);
    w.sat = UNIT_W'(sat);
    w.val = UNIT_W'(val);
    hsv_todo_q.push_back(w);
  endtask

  task automatic check_byte(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_cnt++;
    end
  endtask

  // input driver: hold until taken, then idle or present the next word
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        in_valid_i <= 1'b1;
      end else if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (hsv_todo_q.size() > 0) begin
        hue_i        <= hsv_todo_q[0].hue;
        saturation_i <= hsv_todo_q[0].sat;
        value_i      <= hsv_todo_q[0].val;
        void'(hsv_todo_q.pop_front());
        in_valid_i <= 1'b1;
        if (in_calm > 0) begin
          in_gap <= 0;
          in_calm <= in_calm - 1;
        end else begin
          in_gap <= pick_gap();
          if ($urandom_range(0, 49) == 0) in_calm <= $urandom_range(20, 80);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall > 0) begin
        out_ready_i <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (out_calm > 0) begin
          out_calm <= out_calm - 1;
        end else begin
          out_stall <= pick_gap();
          if ($urandom_range(0, 49) == 0) out_calm <= $urandom_range(20, 80);
        end
      end
    end
  end

  // monitor: predict on input handshake, compare on output handshake
  always @(posedge clk_i) begin
    rgb_word_t want;
    hsv_word_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        w.hue = hue_i;
        w.sat = saturation_i;
        w.val = value_i;
        rgb_pending_q.push_back(hsv_to_rgb(w));
        words_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (rgb_pending_q.size() == 0) begin
          $error("output word with nothing pending: %0d %0d %0d", red_o, green_o, blue_o);
          fault_cnt++;
        end else begin
          want = rgb_pending_q.pop_front();
          check_byte("red", want.red, red_o);
          check_byte("green", want.green, green_o);
          check_byte("blue", want.blue, blue_o);
        end
      end
    end
    in_taken <= in_valid_i && in_ready_o;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // directed words: sector edges, ends of every field, wrap and clamp
    add_pixel(0, 0, 0);
    add_pixel(0, 256, 256);
    add_pixel(3840, 256, 256);
    add_pixel(7680, 256, 256);
    add_pixel(11520, 256, 256);
    add_pixel(15360, 256, 256);
    add_pixel(19200, 256, 256);
    add_pixel(3839, 256, 256);
    add_pixel(23039, 256, 256);
    add_pixel(23040, 256, 256);
    add_pixel(32767, 511, 511);
    add_pixel(1920, 128, 200);
    add_pixel(5760, 1, 255);
    add_pixel(9600, 255, 1);
    add_pixel(13440, 257, 128);
    add_pixel(17280, 100, 257);
    add_pixel(21120, 300, 300);
    add_pixel(1, 256, 256);
    add_pixel(3841, 200, 256);
    add_pixel(0, 256, 0);
    add_pixel(12345, 0, 256);

    // random words
    repeat (RANDOM_WORDS) add_pixel(pick_hue(), pick_unit(), pick_unit());
    words_total = hsv_todo_q.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < words_total || rgb_pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
